// File: sv/ins_sort_pkg.sv
// ----------------------------------------------------------------------------
// Insertion sorter package
// Word types for the input and result ports and the cell link types.
// ----------------------------------------------------------------------------
package ins_sort_pkg;

  localparam int unsigned ValueW = 32;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     end_of_set;
  } in_word_t;

  typedef struct packed {
    logic signed [ValueW-1:0] sorted_value;
    logic                     final_res;
    logic                     overflowed;
  } out_word_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     valid;
    logic                     ins;    // new word lands at or below this cell
  } link_t;

  typedef struct packed {
    logic insert;  // place the broadcast word this cycle
    logic drain;   // shift the whole row down one place
  } cell_ctrl_t;

endpackage

// File: sv/ins_sort_cell.sv
// ----------------------------------------------------------------------------
// Insertion sorter cell
// One sorted slot: compares against the broadcast word, shifts up on insert
// and down on drain.
// ----------------------------------------------------------------------------
module ins_sort_cell
  import ins_sort_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [ValueW-1:0] new_value_i,
  input  link_t                    left_i,
  input  link_t                    right_i,
  output link_t                    link_o
);

  logic signed [ValueW-1:0] value_q, value_d;
  logic                     valid_q, valid_d;
  logic                     ins;

  // Strictly greater moves up, so equal words keep arrival order.
  assign ins = !valid_q || (value_q > new_value_i);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.drain) begin
      value_d = right_i.value;
      valid_d = right_i.valid;
    end else if (ctrl_i.insert && ins) begin
      value_d = left_i.ins ? left_i.value : new_value_i;
      valid_d = valid_q | left_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o = '{value: value_q, valid: valid_q, ins: ins};

endmodule

// File: sv/insertion_sorter_top.sv
// ----------------------------------------------------------------------------
// Insertion sorter top level
// Systolic insertion sort over one set of signed words at a time.
// ----------------------------------------------------------------------------
// Loading: one word per cycle, busy_o stays low while a set is filling.
// After the closing word is accepted, results follow from the next cycle on,
//   one per cycle, one for each stored word; busy_o is high while they come out.
// The drain length is set by the cell row shifting down one place a cycle.
// Reset clears every cell's valid flag, the drain flag and the drop flag.
// Results are strobed for one cycle each; the receiver cannot stall.
module insertion_sorter_top
  import ins_sort_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  in_word_t  in_i,
  output logic      res_valid_o,
  output out_word_t res_o
);

  // chain[0] is the fixed head, chain[i+1] is cell i, chain[CAPACITY+1]
  // is the empty tail that feeds zeros in while draining.
  link_t      chain [CAPACITY+2];
  cell_ctrl_t ctrl;
  logic       accept;
  logic       full;
  logic       drain_q, drain_d;
  logic       drop_q, drop_d;

  // Head: always valid, never an insertion point, so cell 0 takes the new
  // word directly whenever it is the insertion point.
  assign chain[0] = '{value: '0, valid: 1'b1, ins: 1'b0};
  assign chain[CAPACITY+1] = '{value: '0, valid: 1'b0, ins: 1'b1};

  assign accept = start_i && !drain_q;
  assign full   = chain[CAPACITY].valid;

  assign ctrl.insert = accept && !full;
  assign ctrl.drain  = drain_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ins_sort_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_value_i (in_i.value),
      .left_i      (chain[i]),
      .right_i     (chain[i+2]),
      .link_o      (chain[i+1])
    );
  end

  // Drain runs until the word behind cell 0 is empty; the drop flag lives
  // for the whole set and is cleared with the last result.
  always_comb begin
    drain_d = drain_q;
    drop_d  = drop_q;
    if (drain_q) begin
      if (!chain[2].valid) begin
        drain_d = 1'b0;
        drop_d  = 1'b0;
      end
    end else if (accept) begin
      if (full) begin
        drop_d = 1'b1;
      end
      if (in_i.end_of_set) begin
        drain_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      drop_q  <= 1'b0;
    end else begin
      drain_q <= drain_d;
      drop_q  <= drop_d;
    end
  end

  assign busy_o      = drain_q;
  assign res_valid_o = drain_q;
  assign res_o       = '{sorted_value: chain[1].value,
                         final_res:    !chain[2].valid,
                         overflowed:   drop_q};

endmodule
